// ===== design/flg_pkg.sv =====
// ----------------------------------------------------------------------------
// flg_pkg : shared types and constants of the flanger
// Widths, register indexes, CORDIC table and state encoding.
// ----------------------------------------------------------------------------
package flg_pkg;
   localparam int SampleW = 16;
   localparam int DepthW = 10;
   localparam int Depth = 1 << DepthW;
   localparam int CsrW = 32;
   localparam int CordicSteps = 16;
   localparam int StepW = 4;
   localparam int CordW = 18;
   localparam logic [31:0] LfoStepReset = 32'd97392;
   localparam logic [DepthW-1:0] MinDelayReset = 10'd5;
   localparam logic [DepthW-1:0] MaxDelayReset = 10'd100;
   localparam logic [16:0] PiQ14 = 17'd51472;
   localparam logic signed [CordW-1:0] GainQ14 = 18'sh026DD;
   localparam logic signed [CordW-1:0] SinLimit = 18'sd16384;

   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CsrLfoStep = 2'd0;
   localparam csr_idx_type CsrMinDelay = 2'd1;
   localparam csr_idx_type CsrMaxDelay = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ANGLE, ST_CORDIC, ST_SCALE, ST_READ, ST_MIX, ST_OUT
   } state_type;

   function automatic logic [15:0] atan_q14(input logic [StepW-1:0] i);
      case (i)
         4'd0: return 16'h3243;  4'd1: return 16'h1DAC;
         4'd2: return 16'h0FAD;  4'd3: return 16'h07F5;
         4'd4: return 16'h03FE;  4'd5: return 16'h01FF;
         4'd6: return 16'h00FF;  4'd7: return 16'h007F;
         4'd8: return 16'h003F;  4'd9: return 16'h0020;
         4'd10: return 16'h0010; 4'd11: return 16'h0008;
         4'd12: return 16'h0004; 4'd13: return 16'h0002;
         4'd14: return 16'h0001; default: return 16'h0000;
      endcase
   endfunction
endpackage

// ===== design/flg_stream_if.sv =====
// ----------------------------------------------------------------------------
// flg_stream_if : valid/ready sample channel
// Carries one signed sample per transfer.
// ----------------------------------------------------------------------------
interface flg_stream_if;
   logic valid;
   logic ready;
   logic signed [15:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ===== design/flanger_with_cordic_lfo_core.sv =====
// ----------------------------------------------------------------------------
// flanger_with_cordic_lfo_core : flanger with CORDIC sine LFO
// Mixes each sample with a swept-delay copy from a 1024-entry delay line.
// ----------------------------------------------------------------------------
// Usage: req carries dry_sample, rsp carries mixed_sample; one rsp transfer
// per req transfer. csr_we/csr_index/csr_wdata write lfo_step (0), the
// shortest delay (1) and the longest delay (2); the user must write them
// only while idle, as the block does not enforce it; other indexes are dropped.
// Path: after the req transfer, the phase-to-angle product (ST_ANGLE), the
// shared CORDIC add/shift stage (one rotation a cycle), the sine clamp
// (ST_SCALE), the delay scale product and memory read (ST_READ), the mix
// (ST_MIX), then the output register (ST_OUT) that offers the rsp transfer.
// Occupancy: one item at a time; the CORDIC loop is the longest step.
// Reset: controls set to their reset values, then a clearing pass zeroes all
// 1024 entries of the delay line, during which req_ready stays low.
// Stall: the result waits in the output register; a new req is taken only
// once the previous result has gone.
// ----------------------------------------------------------------------------
module flanger_with_cordic_lfo_core (
   input logic clock,
   input logic reset,
   flg_stream_if.sink req,
   flg_stream_if.source rsp,
   input logic csr_we,
   input flg_pkg::csr_idx_type csr_index,
   input logic [flg_pkg::CsrW-1:0] csr_wdata
);
   import flg_pkg::*;

   state_type state_ff, state_in;
   logic [31:0] step_ff, phase_ff;
   logic [DepthW-1:0] min_ff, max_ff, wp_ff, clr_ff, rd_ff;
   logic clearing_ff;
   logic signed [SampleW-1:0] dry_ff, delayed_ff, mix_ff;
   logic signed [CordW-1:0] x_ff, y_ff, z_ff;
   logic [StepW-1:0] it_ff;
   logic neg_ff;
   logic [31:0] mag_ff;
   logic [DepthW-1:0] span_ff;
   logic [16:0] sinoff_ff;
   logic signed [SampleW-1:0] mem [Depth];

   logic signed [32:0] sv, fold;
   logic [48:0] ang_prod;
   logic signed [CordW-1:0] xs, ys, atn, ysat;
   logic [26:0] dprod;
   logic signed [SampleW:0] sum;

   // fold phase into +/- quarter turn
   always_comb begin
      sv = $signed({phase_ff[31], phase_ff});
      if (sv > 33'sd1073741824) fold = 33'sd2147483648 - sv;
      else if (sv < -33'sd1073741824) fold = -33'sd2147483648 - sv;
      else fold = sv;
      ang_prod = mag_ff * PiQ14;
      xs = x_ff >>> it_ff;
      ys = y_ff >>> it_ff;
      atn = CordW'(signed'({2'b0, atan_q14(it_ff)}));
      ysat = (y_ff > SinLimit) ? SinLimit : ((y_ff < -SinLimit) ? -SinLimit : y_ff);
      dprod = sinoff_ff * span_ff;
      sum = 17'(dry_ff) + 17'(delayed_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid && !clearing_ff) state_in = ST_ANGLE;
         ST_ANGLE: state_in = ST_CORDIC;
         ST_CORDIC: if (it_ff == StepW'(CordicSteps - 1)) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_READ;
         ST_READ: state_in = ST_MIX;
         ST_MIX: state_in = ST_OUT;
         ST_OUT: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !clearing_ff;
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.sample = mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= LfoStepReset;
         min_ff <= MinDelayReset;
         max_ff <= MaxDelayReset;
         phase_ff <= '0;
         wp_ff <= '0;
         clr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CsrLfoStep: step_ff <= csr_wdata;
               CsrMinDelay: min_ff <= csr_wdata[DepthW-1:0];
               CsrMaxDelay: max_ff <= csr_wdata[DepthW-1:0];
               default: ;
            endcase
         end
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == DepthW'(Depth - 1)) clearing_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && req.valid && !clearing_ff) begin
            phase_ff <= phase_ff + step_ff;
         end
         if (state_ff == ST_MIX) wp_ff <= wp_ff + 1'b1;
      end
   end

   // datapath and delay line
   always_ff @(posedge clock) begin
      if (clearing_ff) mem[clr_ff] <= '0;
      case (state_ff)
         ST_IDLE: begin
            dry_ff <= req.sample;
            neg_ff <= fold[32];
            mag_ff <= fold[32] ? 32'(-fold) : fold[31:0];
            span_ff <= (max_ff > min_ff) ? max_ff - min_ff : '0;
         end
         ST_ANGLE: begin
            x_ff <= GainQ14;
            y_ff <= '0;
            z_ff <= neg_ff ? -CordW'(signed'({1'b0, ang_prod[47:31]}))
                           : CordW'(signed'({1'b0, ang_prod[47:31]}));
            it_ff <= '0;
         end
         ST_CORDIC: begin
            if (!z_ff[CordW-1]) begin
               x_ff <= x_ff - ys; y_ff <= y_ff + xs; z_ff <= z_ff - atn;
            end else begin
               x_ff <= x_ff + ys; y_ff <= y_ff - xs; z_ff <= z_ff + atn;
            end
            it_ff <= it_ff + 1'b1;
            sinoff_ff <= 17'(ysat + SinLimit);
         end
         ST_SCALE: begin
            sinoff_ff <= 17'(ysat + SinLimit);
         end
         default: ;
      endcase
      if (state_ff == ST_READ) begin
         rd_ff <= wp_ff - (min_ff + dprod[24:15]);
      end
      if (state_ff == ST_MIX) begin
         mem[wp_ff] <= dry_ff;
         mix_ff <= SampleW'((sum + 17'(sum[SampleW])) >>> 1);
      end
      delayed_ff <= mem[state_ff == ST_READ ? wp_ff - (min_ff + dprod[24:15]) : rd_ff];
   end

   assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req.ready) else $error("item taken during clear");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.sample)))
      else $error("result lost while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("second item taken");
endmodule

// ===== test/flanger_with_cordic_lfo_core_test.sv =====
// ----------------------------------------------------------------------------
// flanger_with_cordic_lfo_core_test : self-checking bench for the flanger
// Drives samples in random bursts, stalls the result channel on its own
// pattern, predicts every mixed sample from a behavioural flanger model kept
// in step with the register writes, and compares each result against it.
// ----------------------------------------------------------------------------
module flanger_with_cordic_lfo_core_test;
   import flg_pkg::*;

   localparam int MaxCycles = 3_000_000;
   localparam int DrainCycles = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_idx_type csr_index = CsrLfoStep;
   logic [CsrW-1:0] csr_wdata = '0;

   flg_stream_if req ();
   flg_stream_if rsp ();

   flanger_with_cordic_lfo_core u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // model state: delay line, pointer, phase and the three registers
   logic signed [15:0] echo_mem [Depth];
   logic [DepthW-1:0] wr_ptr;
   logic [31:0] sweep_phase;
   logic [31:0] step_reg;
   logic [DepthW-1:0] min_reg;
   logic [DepthW-1:0] max_reg;

   logic signed [15:0] mix_queue [$];
   int n_errors = 0;
   int cycle_count = 0;
   bit stall_bursty = 1'b0;
   int gap_max = 4;

   // arithmetic shift that floors, as the datapath does
   function automatic int floor_shift(int v, int s);
      return v >>> s;
   endfunction

   // sine of a 32-bit turn in Q14, folded to +-pi/2 and rotated by CORDIC
   function automatic int lfo_sine_q14(logic [31:0] ph);
      longint sv, mag;
      int theta, x, y, z, xn, xs, ys;
      bit neg;
      int atan_tab [16] = '{'h3243, 'h1DAC, 'h0FAD, 'h07F5, 'h03FE, 'h01FF,
                            'h00FF, 'h007F, 'h003F, 'h0020, 'h0010, 'h0008,
                            'h0004, 'h0002, 'h0001, 'h0000};
      sv = ph[31] ? longint'(ph) - 64'sd4294967296 : longint'(ph);
      if (sv > 64'sd1073741824) sv = 64'sd2147483648 - sv;
      else if (sv < -64'sd1073741824) sv = -64'sd2147483648 - sv;
      neg = sv < 0;
      mag = neg ? -sv : sv;
      theta = int'((mag * 51472) >>> 31);
      z = neg ? -theta : theta;
      x = 'h26DD;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            xn = x - ys; y = y + xs; z -= atan_tab[i];
         end else begin
            xn = x + ys; y = y - xs; z += atan_tab[i];
         end
         x = xn;
      end
      if (y > 16384) y = 16384;
      if (y < -16384) y = -16384;
      return y;
   endfunction

   // advance the model by one sample and return the expected mix
   function automatic logic signed [15:0] flange_sample(logic signed [15:0] dry);
      int sine, span, delay, mix;
      logic [DepthW-1:0] rd;
      logic signed [15:0] delayed;
      sine = lfo_sine_q14(sweep_phase);
      span = (max_reg > min_reg) ? int'(max_reg) - int'(min_reg) : 0;
      sweep_phase += step_reg;
      delay = int'(min_reg) + (((sine + 16384) * span) >> 15);
      rd = wr_ptr - DepthW'(delay);
      delayed = echo_mem[rd];
      echo_mem[wr_ptr] = dry;
      wr_ptr++;
      mix = (int'(dry) + int'(delayed)) / 2;
      return 16'(mix);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      n_errors++;
   endtask

   // write one register while the block is idle and mirror it in the model
   task automatic write_csr(input csr_idx_type idx, input logic [CsrW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CsrLfoStep: step_reg = val;
         CsrMinDelay: min_reg = val[DepthW-1:0];
         CsrMaxDelay: max_reg = val[DepthW-1:0];
         default: ;
      endcase
   endtask

   // offer one sample, hold it until the transfer, then predict its mix
   task automatic send_sample(input logic signed [15:0] dry);
      req.valid <= 1'b1;
      req.sample <= dry;
      do @(posedge clock); while (!req.ready);
      mix_queue.push_back(flange_sample(dry));
      if ($urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every expected result, then let the datapath settle
   task automatic drain();
      end_burst();
      while (mix_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      int left;
      left = count;
      while (left > 0) begin
         for (int b = $urandom_range(1, 40); b > 0 && left > 0; b--) begin
            send_sample(16'($urandom));
            left--;
         end
         end_burst();
         repeat ($urandom_range(0, 2) * $urandom_range(0, 30)) @(posedge clock);
      end
   endtask

   // extremes of the sample under the default sweep and delay settings
   task automatic test_directed();
      logic signed [15:0] edge_vals [8] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
         16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFE};
      foreach (edge_vals[i]) send_sample(edge_vals[i]);
      repeat (6) send_sample(16'sh8000);
      repeat (6) send_sample(16'sh7FFF);
      drain();
   endtask

   // half-turn step: the phase alternates between two points half a turn apart
   task automatic test_half_turn();
      write_csr(CsrLfoStep, 32'h8000_0000);
      write_csr(CsrMinDelay, 32'd1);
      write_csr(CsrMaxDelay, 32'd1023);
      send_random(40);
      drain();
   endtask

   // max below min keeps the delay at min; dead index and high bits dropped
   task automatic test_span_and_masking();
      write_csr(CsrMinDelay, 32'hFFFF_FC00 | 32'd900);
      write_csr(CsrMaxDelay, 32'hFFFF_FC00 | 32'd10);
      write_csr(csr_idx_type'(3), 32'hFFFF_FFFF);
      write_csr(CsrLfoStep, 32'h1234_5678);
      send_random(60);
      drain();
   endtask

   // zero min delay reads the slot written one full turn of the line ago
   task automatic test_zero_delay();
      write_csr(CsrMinDelay, 32'd0);
      write_csr(CsrMaxDelay, 32'd0);
      write_csr(CsrLfoStep, 32'd0);
      send_random(Depth + 80);
      drain();
   endtask

   // random sweeps over several register settings, extremes included
   task automatic test_random_sweeps();
      for (int p = 0; p < 6; p++) begin
         write_csr(CsrLfoStep, (p == 0) ? 32'hFFFF_FFFF : $urandom);
         write_csr(CsrMinDelay, (p == 1) ? 32'd1023 : $urandom_range(0, 1023));
         write_csr(CsrMaxDelay, (p == 2) ? 32'd1023 : $urandom_range(0, 1023));
         stall_bursty = p[0];
         gap_max = p[1] ? 20 : 3;
         send_random(40);
         drain();
      end
   endtask

   // result side: own stall pattern, compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (mix_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp.sample, 0);
            end else begin
               if (rsp.sample !== mix_queue[0])
                  report_mismatch("mixed_sample", rsp.sample, mix_queue[0]);
               void'(mix_queue.pop_front());
            end
         end
         rsp.ready <= stall_bursty ? ($urandom_range(0, 7) > 4)
                                   : ($urandom_range(0, 9) != 0);
      end
   end

   // watchdog: clearing pass, stalls and gaps all fit many times over
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MaxCycles) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.sample = '0;
      foreach (echo_mem[i]) echo_mem[i] = '0;
      wr_ptr = '0;
      sweep_phase = '0;
      step_reg = LfoStepReset;
      min_reg = MinDelayReset;
      max_reg = MaxDelayReset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_half_turn();
      test_span_and_masking();
      test_zero_delay();
      test_random_sweeps();
      if (n_errors == 0 && mix_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
